### rtl/core/wqd_pkg.sv
package wqd_pkg;

    // Built limits of the dispatcher.
    localparam int MAX_QUEUES  = 8;
    localparam int MAX_CAP_LOG = 16;

    // Derived widths.
    localparam int QIDX_W  = $clog2(MAX_QUEUES);
    localparam int QCNT_W  = $clog2(MAX_QUEUES + 1);
    localparam int OCC_W   = MAX_CAP_LOG + 1;

    // Fixed field and register widths.
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 4;
    localparam int CAPLOG_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    // Operation codes of a request.
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Schedule modes.
    localparam logic MODE_RR = 1'b0;
    localparam logic MODE_LL = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TAKEN    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPLOG = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMPL,
        S_DONE
    } wqd_state_t;

    // Count update command to the occupancy store.
    typedef struct packed {
        logic              en;
        logic              inc;
        logic [QIDX_W-1:0] idx;
    } wqd_upd_t;

endpackage

### rtl/core/wqd_occ.sv
module wqd_occ
    import wqd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [QIDX_W-1:0] rd_idx,
    output logic [OCC_W-1:0]  rd_data,
    input  wqd_upd_t          upd
);

    logic [OCC_W-1:0] occ_reg [MAX_QUEUES];

    // One count is read per cycle for the shared comparator.
    assign rd_data = occ_reg[rd_idx];

    // Counts step up on a placed task and down on a taken completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else if (upd.en)
        begin
            if (upd.inc)
            begin
                occ_reg[upd.idx] <= occ_reg[upd.idx] + OCC_W'(1);
            end
            else
            begin
                occ_reg[upd.idx] <= occ_reg[upd.idx] - OCC_W'(1);
            end
        end
    end

endmodule

### rtl/core/worker_queue_dispatcher.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  op, queue_index, task_tag
// output    out        out_valid / out_stall status, chosen_queue, tag_out
// config    in         cfg_we               cfg_index, cfg_data
//
// A submit is accepted, then the shared count comparator visits the queues
// in turn (up to the active queue count), then the result is posted. A
// completion is accepted, checks its queue's count and then posts its result.
// Reset clears all counts, the round-robin pointer and the output valid flag.
// A new request is taken while an earlier result still waits in the output
// register; the sequencer holds its result until that register is free.
module worker_queue_dispatcher
    import wqd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [2:0]            queue_index,
    input  logic [TAG_W-1:0]      task_tag,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [2:0]            chosen_queue,
    output logic [TAG_W-1:0]      tag_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic                mode_reg;
    logic [ACTIVE_W-1:0] active_reg;
    logic [CAPLOG_W-1:0] caplog_reg;

    // Sequencer state.
    wqd_state_t          state_reg, state_next;
    logic [QIDX_W-1:0]   q_reg, q_next;
    logic [QCNT_W-1:0]   k_reg, k_next;
    logic [QIDX_W-1:0]   start_reg, start_next;
    logic [QIDX_W-1:0]   best_reg, best_next;
    logic [OCC_W-1:0]    best_cnt_reg, best_cnt_next;
    logic [QIDX_W-1:0]   ptr_reg, ptr_next;
    logic                op_reg, op_next;

    // Pending result and its count update.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [QIDX_W-1:0]   res_queue_reg, res_queue_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic                res_upd_reg, res_upd_next;
    logic                res_inc_reg, res_inc_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [QIDX_W-1:0]   chosen_reg, chosen_next;
    logic [TAG_W-1:0]    tag_out_reg, tag_out_next;

    // Derived values.
    logic [QCNT_W-1:0]   n_active;
    logic [CAPLOG_W-1:0] cap_log;
    logic [OCC_W-1:0]    cap_val;
    logic [OCC_W-1:0]    rd_data;
    logic                is_full;
    logic                last_step;
    logic [QIDX_W-1:0]   q_wrap;
    logic [QIDX_W-1:0]   scan_start;
    logic [QIDX_W-1:0]   cand_best;
    logic [OCC_W-1:0]    cand_cnt;
    logic                out_free;
    wqd_upd_t            upd;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RR;
            active_reg <= ACTIVE_W'(1);
            caplog_reg <= CAPLOG_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_ACTIVE: active_reg <= cfg_data[ACTIVE_W-1:0];
                CFG_CAPLOG: caplog_reg <= cfg_data[CAPLOG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Clamp the active count and the capacity to the built limits.
    always_comb
    begin
        if (active_reg == '0)
        begin
            n_active = QCNT_W'(1);
        end
        else if (active_reg > ACTIVE_W'(MAX_QUEUES))
        begin
            n_active = QCNT_W'(MAX_QUEUES);
        end
        else
        begin
            n_active = QCNT_W'(active_reg);
        end
        if (caplog_reg == '0)
        begin
            cap_log = CAPLOG_W'(1);
        end
        else if (caplog_reg > CAPLOG_W'(MAX_CAP_LOG))
        begin
            cap_log = CAPLOG_W'(MAX_CAP_LOG);
        end
        else
        begin
            cap_log = caplog_reg;
        end
    end

    assign cap_val = OCC_W'(1) << cap_log;

    // Occupancy counts, read at the current scan or completion queue index.
    wqd_occ u_occ (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (q_reg),
        .rd_data (rd_data),
        .upd     (upd)
    );

    // Shared comparator path and scan helpers.
    assign is_full    = (rd_data >= cap_val);
    assign last_step  = (k_reg == n_active - QCNT_W'(1));
    assign q_wrap     = ((QCNT_W'(q_reg) + QCNT_W'(1)) == n_active) ?
                        '0 : q_reg + QIDX_W'(1);
    assign scan_start = (QCNT_W'(ptr_reg) < n_active) ? ptr_reg : '0;
    assign out_free   = !out_valid_reg || !out_stall;

    // Running minimum for least-loaded mode.
    always_comb
    begin
        if ((k_reg == '0) || (rd_data < best_cnt_reg))
        begin
            cand_best = q_reg;
            cand_cnt  = rd_data;
        end
        else
        begin
            cand_best = best_reg;
            cand_cnt  = best_cnt_reg;
        end
    end

    // Sequencer next state and outputs.
    always_comb
    begin
        state_next      = state_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        start_next      = start_reg;
        best_next       = best_reg;
        best_cnt_next   = best_cnt_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_queue_next  = res_queue_reg;
        res_tag_next    = res_tag_reg;
        res_upd_next    = res_upd_reg;
        res_inc_next    = res_inc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        chosen_next     = chosen_reg;
        tag_out_next    = tag_out_reg;
        upd             = '{en: 1'b0, inc: res_inc_reg, idx: res_queue_reg};
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    k_next  = '0;
                    if (op == OP_COMPLETE)
                    begin
                        q_next       = queue_index;
                        res_tag_next = '0;
                        state_next   = S_COMPL;
                    end
                    else
                    begin
                        res_tag_next = task_tag;
                        start_next   = scan_start;
                        q_next       = (mode_reg == MODE_RR) ? scan_start : '0;
                        state_next   = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (mode_reg == MODE_RR)
                begin
                    // First queue from the pointer onward that has room.
                    if (!is_full)
                    begin
                        res_status_next = STAT_PLACED;
                        res_queue_next  = q_reg;
                        res_upd_next    = 1'b1;
                        res_inc_next    = 1'b1;
                        ptr_next        = q_wrap;
                        state_next      = S_DONE;
                    end
                    else if (last_step)
                    begin
                        res_status_next = STAT_REJECTED;
                        res_queue_next  = '0;
                        res_upd_next    = 1'b0;
                        ptr_next        = start_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        q_next = q_wrap;
                        k_next = k_reg + QCNT_W'(1);
                    end
                end
                else
                begin
                    // An empty queue wins at once; otherwise keep the minimum.
                    if (rd_data == '0)
                    begin
                        res_status_next = STAT_PLACED;
                        res_queue_next  = q_reg;
                        res_upd_next    = 1'b1;
                        res_inc_next    = 1'b1;
                        state_next      = S_DONE;
                    end
                    else if (last_step)
                    begin
                        if (cand_cnt >= cap_val)
                        begin
                            res_status_next = STAT_REJECTED;
                            res_queue_next  = '0;
                            res_upd_next    = 1'b0;
                        end
                        else
                        begin
                            res_status_next = STAT_PLACED;
                            res_queue_next  = cand_best;
                            res_upd_next    = 1'b1;
                            res_inc_next    = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        best_next     = cand_best;
                        best_cnt_next = cand_cnt;
                        q_next        = q_reg + QIDX_W'(1);
                        k_next        = k_reg + QCNT_W'(1);
                    end
                end
            end

            S_COMPL:
            begin
                // A completion counts only for an active, nonempty queue.
                res_queue_next = q_reg;
                res_inc_next   = 1'b0;
                if ((QCNT_W'(q_reg) < n_active) && (rd_data != '0))
                begin
                    res_status_next = STAT_TAKEN;
                    res_upd_next    = 1'b1;
                end
                else
                begin
                    res_status_next = STAT_IGNORED;
                    res_upd_next    = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Post the result and apply the count change together.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    chosen_next    = res_queue_reg;
                    tag_out_next   = res_tag_reg;
                    upd.en         = res_upd_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        k_reg          <= k_next;
        start_reg      <= start_next;
        best_reg       <= best_next;
        best_cnt_reg   <= best_cnt_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_queue_reg  <= res_queue_next;
        res_tag_reg    <= res_tag_next;
        res_upd_reg    <= res_upd_next;
        res_inc_reg    <= res_inc_next;
        status_reg     <= status_next;
        chosen_reg     <= chosen_next;
        tag_out_reg    <= tag_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_queue = chosen_reg;
    assign tag_out      = tag_out_reg;

    // A new result only appears after the sequencer finished a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result posted outside the done state");

    // The scan never visits more queues than are active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < n_active))
        else $error("scan counter ran past the active queues");

    // A placed task always lands in an active queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_PLACED)) |-> (QCNT_W'(chosen_queue) < n_active))
        else $error("task placed in an inactive queue");

    // Submit results carry a status of their own kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg == OP_SUBMIT) |->
        (res_status_reg == STAT_PLACED || res_status_reg == STAT_REJECTED))
        else $error("submit finished with a completion status");

endmodule
